### src/eic_pkg.sv
// shared constants, codes and widths for the ipv4 receive classifier
package eic_pkg;

   localparam int MAX_FRAME = 2048;
   localparam int CNT_W     = $clog2(MAX_FRAME + 1);

   localparam int ETH_HDR       = 14;
   localparam int IP_MIN_HDR    = 20;
   localparam int TRANSPORT_MIN = 8;

   localparam logic [15:0] ET_ARP      = 16'h0806;
   localparam logic [15:0] ET_IPV4     = 16'h0800;
   localparam logic [7:0]  PROTO_ICMP  = 8'd1;
   localparam logic [7:0]  PROTO_TCP   = 8'd6;
   localparam logic [7:0]  PROTO_UDP   = 8'd17;
   localparam logic [7:0]  ICMP_ECHO   = 8'd8;
   localparam logic [15:0] DHCP_CLIENT = 16'd68;
   localparam logic [31:0] BROADCAST   = 32'hFFFF_FFFF;
   localparam logic [3:0]  IHL_MASK    = 4'hF;

   // frame offsets of the captured header fields
   localparam int POS_ET_HI  = 12;
   localparam int POS_ET_LO  = 13;
   localparam int POS_IHL    = 14;
   localparam int POS_TOT_HI = 16;
   localparam int POS_TOT_LO = 17;
   localparam int POS_PROTO  = 23;
   localparam int POS_SRC    = 26;
   localparam int POS_DST    = 30;

   typedef enum logic [2:0] {
      VERDICT_DROP = 3'd0,
      VERDICT_ARP  = 3'd1,
      VERDICT_ICMP = 3'd2,
      VERDICT_DHCP = 3'd3,
      VERDICT_DNS  = 3'd4,
      VERDICT_TCP  = 3'd5
   } verdict_type;

   typedef enum logic [1:0] {
      CSR_OWN_ADDRESS   = 2'd0,
      CSR_DHCP_RUNNING  = 2'd1,
      CSR_RESOLVER_PORT = 2'd2
   } csr_index_type;

   // per-frame capture state
   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic [15:0]      ether_type;
      logic [5:0]       header_bytes;
      logic [15:0]      ip_total;
      logic [7:0]       ip_protocol;
      logic [31:0]      src_addr;
      logic [31:0]      dst_addr;
      logic [7:0]       transport_first;
      logic [15:0]      udp_port;
      logic [15:0]      udp_len;
   } frame_type;

endpackage

### src/eth_ipv4_rx_classifier_unit.sv
// ethernet ipv4 receive classifier top level
//
// usage
//  - req channel: one frame byte per word, req_last_byte marks the frame end;
//    a word is taken on a clock edge with req_valid and req_ready both high
//  - rsp channel: exactly one verdict word per frame, issued for its last byte;
//    no words for the other bytes
//  - csr port: own address (0), dhcp running (1), resolver port (2), written
//    on csr_write_enable; user writes only while the block is idle, unchecked
//  - throughput: one byte per cycle, frames back to back, unless rsp stalls
//  - result path: once the last byte is accepted into the input register,
//    the capture stage loads the snapshot, then the classify logic loads the
//    result register, which drives rsp_valid
//  - a finished frame snapshot waits in its own register, so the next frame
//    keeps streaming while a verdict is still held on the rsp side; bytes
//    stall only when a second last byte meets a full snapshot and result
//  - reset clears the capture state, all valid flags and the csr values;
//    no clearing pass, the block takes words on the first cycle after reset
//  - bytes beyond the frame maximum are ignored and the length saturates
module eth_ipv4_rx_classifier_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_frame_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_verdict,
   output logic [31:0] rsp_source_address,
   output logic [6:0]  rsp_payload_offset,
   output logic [10:0] rsp_payload_length,
   output logic [15:0] rsp_dest_port,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data
);
   import eic_pkg::*;

   // configuration registers
   logic [31:0] own_address_ff;
   logic        dhcp_running_ff;
   logic [15:0] resolver_port_ff;

   // input register
   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;

   // capture state and finished-frame snapshot
   frame_type   frame_ff, frame_in;
   frame_type   snap_ff;
   logic        snap_valid_ff;

   // result register
   logic        rsp_valid_ff;
   logic [2:0]  verdict_ff, verdict_in;
   logic [31:0] source_ff, source_in;
   logic [6:0]  offset_ff, offset_in;
   logic [10:0] length_ff, length_in;
   logic [15:0] port_ff, port_in;

   // flow control
   logic out_free, snap_move, snap_free, in_move, req_take;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign snap_move = snap_valid_ff && out_free;
   assign snap_free = !snap_valid_ff || out_free;
   // a non-final byte only updates the capture state, so it never waits
   assign in_move   = in_valid_ff && (!in_last_ff || snap_free);
   assign req_ready = !in_valid_ff || in_move;
   assign req_take  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_address_ff   <= '0;
         dhcp_running_ff  <= 1'b0;
         resolver_port_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_OWN_ADDRESS:   own_address_ff   <= csr_write_data;
            CSR_DHCP_RUNNING:  dhcp_running_ff  <= csr_write_data[0];
            CSR_RESOLVER_PORT: resolver_port_ff <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (in_move) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_frame_byte;
         in_last_ff <= req_last_byte;
      end
   end

   // field capture for the byte in the input register
   logic [CNT_W-1:0] pos;
   logic [CNT_W-1:0] t_pos;
   logic             pos_ok;

   always_comb begin
      frame_in = frame_ff;
      pos      = frame_ff.count;
      t_pos    = CNT_W'(ETH_HDR) + CNT_W'(frame_ff.header_bytes);
      pos_ok   = frame_ff.count < CNT_W'(MAX_FRAME);
      if (pos_ok) begin
         frame_in.count = frame_ff.count + CNT_W'(1);
         if (pos == CNT_W'(POS_ET_HI)) begin
            frame_in.ether_type[15:8] = in_byte_ff;
         end else if (pos == CNT_W'(POS_ET_LO)) begin
            frame_in.ether_type[7:0] = in_byte_ff;
         end else if (pos == CNT_W'(POS_IHL)) begin
            frame_in.header_bytes = {in_byte_ff[3:0] & IHL_MASK, 2'b00};
         end else if (pos == CNT_W'(POS_TOT_HI)) begin
            frame_in.ip_total[15:8] = in_byte_ff;
         end else if (pos == CNT_W'(POS_TOT_LO)) begin
            frame_in.ip_total[7:0] = in_byte_ff;
         end else if (pos == CNT_W'(POS_PROTO)) begin
            frame_in.ip_protocol = in_byte_ff;
         end else if (pos >= CNT_W'(POS_SRC) && pos < CNT_W'(POS_DST)) begin
            frame_in.src_addr = {frame_ff.src_addr[23:0], in_byte_ff};
         end else if (pos >= CNT_W'(POS_DST) && pos < CNT_W'(POS_DST + 4)) begin
            frame_in.dst_addr = {frame_ff.dst_addr[23:0], in_byte_ff};
         end
         // transport header, located by the header length seen so far
         if (pos > CNT_W'(POS_IHL)) begin
            if (pos == t_pos) begin
               frame_in.transport_first = in_byte_ff;
            end else if (pos == t_pos + CNT_W'(2)) begin
               frame_in.udp_port[15:8] = in_byte_ff;
            end else if (pos == t_pos + CNT_W'(3)) begin
               frame_in.udp_port[7:0] = in_byte_ff;
            end else if (pos == t_pos + CNT_W'(4)) begin
               frame_in.udp_len[15:8] = in_byte_ff;
            end else if (pos == t_pos + CNT_W'(5)) begin
               frame_in.udp_len[7:0] = in_byte_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= '0;
      end else if (in_move) begin
         // a finished frame leaves for the snapshot and capture starts afresh
         frame_ff <= in_last_ff ? '0 : frame_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         snap_valid_ff <= 1'b0;
      end else if (in_move && in_last_ff) begin
         snap_valid_ff <= 1'b1;
      end else if (snap_move) begin
         snap_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_move && in_last_ff) begin
         snap_ff <= frame_in;
      end
   end

   // classification of the snapshot
   logic [15:0] len16, hb16, total, plen, ulen;
   logic        ip_ok, dst_ok;
   logic [2:0]  v;

   always_comb begin
      verdict_in = VERDICT_DROP;
      source_in  = '0;
      offset_in  = '0;
      length_in  = '0;
      port_in    = '0;
      v          = VERDICT_DROP;
      len16      = 16'(snap_ff.count - CNT_W'(ETH_HDR));
      hb16       = 16'(snap_ff.header_bytes);
      total      = (snap_ff.ip_total > len16) ? len16 : snap_ff.ip_total;
      plen       = total - hb16;
      ulen       = (snap_ff.udp_len > plen) ? plen : snap_ff.udp_len;
      ip_ok      = snap_ff.ether_type == ET_IPV4 && len16 >= 16'(IP_MIN_HDR) &&
                   hb16 >= 16'(IP_MIN_HDR) && hb16 <= len16;
      dst_ok     = snap_ff.dst_addr == own_address_ff || snap_ff.dst_addr == BROADCAST ||
                   dhcp_running_ff;
      if (snap_ff.count >= CNT_W'(ETH_HDR)) begin
         if (snap_ff.ether_type == ET_ARP) begin
            verdict_in = VERDICT_ARP;
            offset_in  = 7'(ETH_HDR);
            length_in  = len16[10:0];
         end else if (ip_ok && total >= hb16 && dst_ok) begin
            if (snap_ff.ip_protocol == PROTO_ICMP) begin
               if (plen >= 16'(TRANSPORT_MIN) && snap_ff.transport_first == ICMP_ECHO) begin
                  v         = VERDICT_ICMP;
                  length_in = plen[10:0];
               end
            end else if (snap_ff.ip_protocol == PROTO_UDP) begin
               if (plen >= 16'(TRANSPORT_MIN)) begin
                  if (snap_ff.udp_port == DHCP_CLIENT && dhcp_running_ff) begin
                     v = VERDICT_DHCP;
                  end else if (snap_ff.udp_port == resolver_port_ff) begin
                     v = VERDICT_DNS;
                  end
                  if (v != VERDICT_DROP) begin
                     length_in = ulen[10:0];
                     port_in   = snap_ff.udp_port;
                  end
               end
            end else if (snap_ff.ip_protocol == PROTO_TCP) begin
               v         = VERDICT_TCP;
               length_in = plen[10:0];
            end
            if (v != VERDICT_DROP) begin
               verdict_in = v;
               source_in  = snap_ff.src_addr;
               offset_in  = 7'(ETH_HDR) + 7'(snap_ff.header_bytes);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (snap_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (snap_move) begin
         verdict_ff <= verdict_in;
         source_ff  <= source_in;
         offset_ff  <= offset_in;
         length_ff  <= length_in;
         port_ff    <= port_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_verdict        = verdict_ff;
   assign rsp_source_address = source_ff;
   assign rsp_payload_offset = offset_ff;
   assign rsp_payload_length = length_ff;
   assign rsp_dest_port      = port_ff;

endmodule

### src/eic_checker.sv
// port-level checks for the ipv4 receive classifier, bound to the top level
module eic_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_verdict,
   input logic [31:0] rsp_source_address,
   input logic [6:0]  rsp_payload_offset,
   input logic [10:0] rsp_payload_length,
   input logic [15:0] rsp_dest_port
);
   import eic_pkg::*;

   // a held result word keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_verdict) &&
      $stable(rsp_source_address) && $stable(rsp_payload_offset) &&
      $stable(rsp_payload_length) && $stable(rsp_dest_port))
      else $error("rsp word changed while stalled");

   // no result straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // a drop carries all-zero fields
   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_verdict == VERDICT_DROP |-> rsp_source_address == '0 &&
      rsp_payload_offset == '0 && rsp_payload_length == '0 && rsp_dest_port == '0)
      else $error("drop word with non-zero fields");

   // arp payload starts right after the ethernet header, no address or port
   a_arp_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_verdict == VERDICT_ARP |-> rsp_payload_offset == 7'(ETH_HDR) &&
      rsp_source_address == '0 && rsp_dest_port == '0)
      else $error("arp word fields wrong");

   // port only for udp classes
   a_port_udp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dest_port != '0 |->
      rsp_verdict == VERDICT_DHCP || rsp_verdict == VERDICT_DNS)
      else $error("port on a non-udp verdict");

endmodule

bind eth_ipv4_rx_classifier_unit eic_checker u_eic_checker (.*);

### verif/verdict_board_pkg.sv
`timescale 1ns / 1ps
// frame verdict predictor and result checker for the ipv4 receive classifier
package verdict_board_pkg;
   import eic_pkg::*;

   typedef struct packed {
      logic [2:0]  verdict;
      logic [31:0] source;
      logic [6:0]  offset;
      logic [10:0] length;
      logic [15:0] port;
   } verdict_word_type;

   class verdict_board;
      logic [31:0] own_address;
      logic        dhcp_running;
      logic [15:0] resolver_port;

      int unsigned byte_count;
      logic [15:0] ether_type;
      logic [5:0]  header_bytes;
      logic [15:0] ip_total;
      logic [7:0]  ip_protocol;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [7:0]  transport_first;
      logic [15:0] udp_port;
      logic [15:0] udp_len;

      verdict_word_type expected_verdicts[$];
      int errors;

      function new();
         own_address   = '0;
         dhcp_running  = 1'b0;
         resolver_port = '0;
         errors        = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         byte_count      = 0;
         ether_type      = '0;
         header_bytes    = '0;
         ip_total        = '0;
         ip_protocol     = '0;
         src_addr        = '0;
         dst_addr        = '0;
         transport_first = '0;
         udp_port        = '0;
         udp_len         = '0;
      endfunction

      function void set_register(csr_index_type index, logic [31:0] value);
         case (index)
            CSR_OWN_ADDRESS:   own_address   = value;
            CSR_DHCP_RUNNING:  dhcp_running  = value[0];
            CSR_RESOLVER_PORT: resolver_port = value[15:0];
            default: ;
         endcase
      endfunction

      function void capture_byte(int unsigned pos, logic [7:0] b);
         int unsigned t;
         // transport start uses the header length held before this byte
         t = ETH_HDR + header_bytes;
         if (pos == POS_ET_HI) ether_type[15:8] = b;
         else if (pos == POS_ET_LO) ether_type[7:0] = b;
         else if (pos == POS_IHL) header_bytes = {b[3:0] & IHL_MASK, 2'b00};
         else if (pos == POS_TOT_HI) ip_total[15:8] = b;
         else if (pos == POS_TOT_LO) ip_total[7:0] = b;
         else if (pos == POS_PROTO) ip_protocol = b;
         else if (pos >= POS_SRC && pos < POS_SRC + 4) src_addr = {src_addr[23:0], b};
         else if (pos >= POS_DST && pos < POS_DST + 4) dst_addr = {dst_addr[23:0], b};
         if (pos > POS_IHL) begin
            if (pos == t) transport_first = b;
            else if (pos == t + 2) udp_port[15:8] = b;
            else if (pos == t + 3) udp_port[7:0] = b;
            else if (pos == t + 4) udp_len[15:8] = b;
            else if (pos == t + 5) udp_len[7:0] = b;
         end
      endfunction

      function verdict_word_type classify_frame();
         verdict_word_type r;
         int unsigned len, total, plen, ulen;
         logic accept;
         r = '0;
         if (byte_count >= ETH_HDR) begin
            len = byte_count - ETH_HDR;
            if (ether_type == ET_ARP) begin
               r.verdict = VERDICT_ARP;
               r.offset  = 7'(ETH_HDR);
               r.length  = 11'(len);
            end else if (ether_type == ET_IPV4 && len >= IP_MIN_HDR &&
                         header_bytes >= IP_MIN_HDR && header_bytes <= len) begin
               total  = (ip_total > len) ? len : ip_total;
               accept = dst_addr == own_address || dst_addr == BROADCAST || dhcp_running;
               if (total >= header_bytes && accept) begin
                  plen = total - header_bytes;
                  case (ip_protocol)
                     PROTO_ICMP: begin
                        if (plen >= TRANSPORT_MIN && transport_first == ICMP_ECHO) begin
                           r.verdict = VERDICT_ICMP;
                           r.length  = 11'(plen);
                        end
                     end
                     PROTO_UDP: begin
                        if (plen >= TRANSPORT_MIN) begin
                           ulen = (udp_len > plen) ? plen : udp_len;
                           if (udp_port == DHCP_CLIENT && dhcp_running)
                              r.verdict = VERDICT_DHCP;
                           else if (udp_port == resolver_port)
                              r.verdict = VERDICT_DNS;
                           if (r.verdict != VERDICT_DROP) begin
                              r.length = 11'(ulen);
                              r.port   = udp_port;
                           end
                        end
                     end
                     PROTO_TCP: begin
                        r.verdict = VERDICT_TCP;
                        r.length  = 11'(plen);
                     end
                     default: ;
                  endcase
                  if (r.verdict != VERDICT_DROP) begin
                     r.source = src_addr;
                     r.offset = 7'(ETH_HDR + header_bytes);
                  end
               end
            end
         end
         return r;
      endfunction

      function void take_byte(logic [7:0] value, logic last);
         if (byte_count < MAX_FRAME) begin
            capture_byte(byte_count, value);
            byte_count++;
         end
         if (last) begin
            expected_verdicts.push_back(classify_frame());
            clear_frame();
         end
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_verdict(verdict_word_type got);
         verdict_word_type want;
         if (expected_verdicts.size() == 0) begin
            $display("%0t verdict word %0d arrived with no frame outstanding",
                     $time, got.verdict);
            errors++;
            return;
         end
         want = expected_verdicts.pop_front();
         compare_field("verdict", 32'(want.verdict), 32'(got.verdict));
         compare_field("source_address", want.source, got.source);
         compare_field("payload_offset", 32'(want.offset), 32'(got.offset));
         compare_field("payload_length", 32'(want.length), 32'(got.length));
         compare_field("dest_port", 32'(want.port), 32'(got.port));
      endfunction

      function int pending();
         return expected_verdicts.size();
      endfunction
   endclass

endpackage

### verif/tb_top.sv
`timescale 1ns / 1ps
// top-level testbench for the ethernet ipv4 receive classifier
module tb_top;
   import eic_pkg::*;
   import verdict_board_pkg::*;

   // cycles with no word moving on either channel before the run is abandoned
   localparam int QUIET_LIMIT  = 4000;
   // the result passes the snapshot and result registers, so allow a margin
   localparam int DRAIN_CYCLES = 10;
   localparam int PHASE_COUNT  = 8;
   localparam logic [31:0] HOME_ADDR = 32'hC0A8_0105;
   localparam logic [15:0] DNS_PORT  = 16'd53;

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_ready;
   logic [7:0]  req_frame_byte   = '0;
   logic        req_last_byte    = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready        = 1'b0;
   logic [2:0]  rsp_verdict;
   logic [31:0] rsp_source_address;
   logic [6:0]  rsp_payload_offset;
   logic [10:0] rsp_payload_length;
   logic [15:0] rsp_dest_port;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index        = '0;
   logic [31:0] csr_write_data   = '0;

   // idling percentages of the current phase
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int quiet_cycles   = 0;

   int unsigned bytes_sent;
   int unsigned frames_sent;
   logic [31:0] own_addr_now;
   logic [15:0] resolver_now;

   // frame under construction, sent first byte first
   logic [7:0] frame_buf[$];

   verdict_board board;

   eth_ipv4_rx_classifier_unit DUT (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // result side: check every accepted word, then pick the next ready level
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            board.check_verdict({rsp_verdict, rsp_source_address, rsp_payload_offset,
                                 rsp_payload_length, rsp_dest_port});
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog: restarts whenever a word moves on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // one byte word: random gaps first, then hold valid until it is taken
   task automatic send_byte(input logic [7:0] value, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_frame_byte <= value;
      req_last_byte  <= last;
      do @(posedge clock); while (!req_ready);
      board.take_byte(value, last);
   endtask

   task automatic send_frame();
      int i;
      for (i = 0; i < frame_buf.size(); i++)
         send_byte(frame_buf[i], i == frame_buf.size() - 1);
      bytes_sent += frame_buf.size();
      frames_sent++;
   endtask

   // registers are written back to back, enable dropped once at the end
   task automatic program_registers(input logic [31:0] own, input logic dhcp,
                                    input logic [15:0] resolver);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_OWN_ADDRESS;
      csr_write_data   <= own;
      @(posedge clock);
      board.set_register(CSR_OWN_ADDRESS, own);
      csr_index        <= CSR_DHCP_RUNNING;
      csr_write_data   <= {31'b0, dhcp};
      @(posedge clock);
      board.set_register(CSR_DHCP_RUNNING, {31'b0, dhcp});
      csr_index        <= CSR_RESOLVER_PORT;
      csr_write_data   <= {16'b0, resolver};
      @(posedge clock);
      board.set_register(CSR_RESOLVER_PORT, {16'b0, resolver});
      csr_write_enable <= 1'b0;
      own_addr_now = own;
      resolver_now = resolver;
   endtask

   // wait for every outstanding verdict, then let the pipeline run dry
   task automatic settle();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic void add_random(input int count);
      repeat (count) frame_buf.push_back(8'($urandom_range(255)));
   endfunction

   function automatic void cut_to(input int target);
      while (frame_buf.size() > target) void'(frame_buf.pop_back());
   endfunction

   // random mac addresses followed by the given ethertype
   function automatic void start_frame(input logic [15:0] etype);
      frame_buf.delete();
      add_random(12);
      frame_buf.push_back(etype[15:8]);
      frame_buf.push_back(etype[7:0]);
   endfunction

   // ipv4 frame; first, port and ulen land at the transport offsets
   function automatic void build_ipv4(input logic [3:0] ihl, input logic [15:0] total,
                                      input logic [7:0] proto, input logic [31:0] dst,
                                      input int payload, input logic [7:0] first,
                                      input logic [15:0] port, input logic [15:0] ulen);
      int hdr, i;
      logic [3:0]  version;
      logic [31:0] src;
      hdr     = (ihl < 5) ? 20 : int'(ihl) * 4;
      src     = $urandom();
      // the upper nibble is ignored, so it is sometimes scrambled
      version = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'd4;
      start_frame(ET_IPV4);
      frame_buf.push_back({version, ihl});
      add_random(1);
      frame_buf.push_back(total[15:8]);
      frame_buf.push_back(total[7:0]);
      add_random(5);
      frame_buf.push_back(proto);
      add_random(2);
      for (i = 3; i >= 0; i--) frame_buf.push_back(src[i*8 +: 8]);
      for (i = 3; i >= 0; i--) frame_buf.push_back(dst[i*8 +: 8]);
      add_random(hdr - 20);
      for (i = 0; i < payload; i++) begin
         case (i)
            0:       frame_buf.push_back(first);
            2:       frame_buf.push_back(port[15:8]);
            3:       frame_buf.push_back(port[7:0]);
            4:       frame_buf.push_back(ulen[15:8]);
            5:       frame_buf.push_back(ulen[7:0]);
            default: frame_buf.push_back(8'($urandom_range(255)));
         endcase
      end
   endfunction

   // mostly well-formed ipv4 with random content, the rest noise and odd frames
   function automatic void make_random_frame();
      int kind, sel, hdr, payload;
      logic [3:0]  ihl;
      logic [7:0]  proto, first;
      logic [31:0] dst;
      logic [15:0] total, port, ulen;
      kind = $urandom_range(99);
      if (kind < 6) begin
         frame_buf.delete();
         add_random($urandom_range(1, 13));
      end else if (kind < 14) begin
         start_frame(ET_ARP);
         add_random($urandom_range(0, 50));
      end else if (kind < 20) begin
         start_frame(16'($urandom_range(16'hFFFF)));
         add_random($urandom_range(0, 60));
      end else begin
         sel = $urandom_range(99);
         if (sel < 80) ihl = 4'd5;
         else if (sel < 92) ihl = 4'($urandom_range(6, 15));
         else ihl = 4'($urandom_range(0, 4));
         hdr = (ihl < 5) ? 20 : int'(ihl) * 4;

         sel = $urandom_range(99);
         if (sel < 30) proto = PROTO_UDP;
         else if (sel < 55) proto = PROTO_ICMP;
         else if (sel < 85) proto = PROTO_TCP;
         else proto = 8'($urandom_range(255));

         sel = $urandom_range(99);
         if (sel < 60) dst = own_addr_now;
         else if (sel < 75) dst = BROADCAST;
         else dst = $urandom();

         payload = ($urandom_range(99) < 15) ? $urandom_range(0, 7) : $urandom_range(8, 40);

         // total length: matching, random, below the header, or past the frame
         sel = $urandom_range(99);
         if (sel < 75) total = 16'(hdr + payload);
         else if (sel < 85) total = 16'($urandom_range(16'hFFFF));
         else if (sel < 95) total = 16'($urandom_range(0, hdr - 1));
         else total = 16'(hdr + payload + int'($urandom_range(1, 30)));

         if (proto == PROTO_ICMP && $urandom_range(99) < 70) first = ICMP_ECHO;
         else first = 8'($urandom_range(255));

         sel = $urandom_range(99);
         if (sel < 30) port = DHCP_CLIENT;
         else if (sel < 70) port = resolver_now;
         else port = 16'($urandom_range(16'hFFFF));

         sel = $urandom_range(99);
         if (sel < 60) ulen = 16'(payload);
         else if (sel < 80) ulen = 16'($urandom_range(0, payload));
         else ulen = 16'($urandom_range(16'hFFFF));

         build_ipv4(ihl, total, proto, dst, payload, first, port, ulen);

         // cut short or padded now and then
         sel = $urandom_range(99);
         if (sel < 12) cut_to($urandom_range(1, frame_buf.size()));
         else if (sel < 22) add_random($urandom_range(1, 20));
      end
   endfunction

   // hand-picked frames, run with own address HOME_ADDR and dns on port 53
   task automatic run_directed();
      // lone final byte, and one byte short of a full ethernet header
      frame_buf.delete();
      add_random(1);
      send_frame();
      frame_buf.delete();
      add_random(13);
      send_frame();
      // arp with an empty payload, then a normal arp frame
      start_frame(ET_ARP);
      send_frame();
      start_frame(ET_ARP);
      add_random(28);
      send_frame();
      // icmp echo request, echo reply, and an echo with too little payload
      build_ipv4(4'd5, 16'd36, PROTO_ICMP, HOME_ADDR, 16, ICMP_ECHO, 16'd0, 16'd0);
      send_frame();
      build_ipv4(4'd5, 16'd28, PROTO_ICMP, HOME_ADDR, 8, 8'd0, 16'd0, 16'd0);
      send_frame();
      build_ipv4(4'd5, 16'd24, PROTO_ICMP, HOME_ADDR, 4, ICMP_ECHO, 16'd0, 16'd0);
      send_frame();
      // dns with udp length past the payload and shorter than it
      build_ipv4(4'd5, 16'd50, PROTO_UDP, HOME_ADDR, 30, 8'd0, DNS_PORT, 16'd200);
      send_frame();
      build_ipv4(4'd5, 16'd50, PROTO_UDP, BROADCAST, 30, 8'd0, DNS_PORT, 16'd12);
      send_frame();
      // dhcp client port while negotiation is off, and a udp stub
      build_ipv4(4'd5, 16'd40, PROTO_UDP, HOME_ADDR, 20, 8'd0, DHCP_CLIENT, 16'd20);
      send_frame();
      build_ipv4(4'd5, 16'd26, PROTO_UDP, HOME_ADDR, 6, 8'd0, DNS_PORT, 16'd6);
      send_frame();
      // tcp to broadcast, to a foreign host, and an unknown protocol
      build_ipv4(4'd5, 16'd32, PROTO_TCP, BROADCAST, 12, 8'd0, 16'd0, 16'd0);
      send_frame();
      build_ipv4(4'd5, 16'd32, PROTO_TCP, 32'h0A00_0001, 12, 8'd0, 16'd0, 16'd0);
      send_frame();
      build_ipv4(4'd5, 16'd32, 8'd47, HOME_ADDR, 12, 8'd0, 16'd0, 16'd0);
      send_frame();
      // header length too small, at its maximum, and past the received bytes
      build_ipv4(4'd4, 16'd32, PROTO_TCP, HOME_ADDR, 12, 8'd0, 16'd0, 16'd0);
      send_frame();
      build_ipv4(4'd15, 16'd72, PROTO_TCP, HOME_ADDR, 12, 8'd0, 16'd0, 16'd0);
      send_frame();
      build_ipv4(4'd15, 16'd60, PROTO_TCP, HOME_ADDR, 0, 8'd0, 16'd0, 16'd0);
      cut_to(ETH_HDR + 50);
      send_frame();
      // total length under the header, and far past the received bytes
      build_ipv4(4'd6, 16'd10, PROTO_TCP, HOME_ADDR, 20, 8'd0, 16'd0, 16'd0);
      send_frame();
      build_ipv4(4'd5, 16'hFFFF, PROTO_UDP, HOME_ADDR, 20, 8'd0, DNS_PORT, 16'hFFFF);
      send_frame();
      // foreign ethertype, and an ipv4 frame too short for any header
      start_frame(16'h86DD);
      add_random(12);
      send_frame();
      start_frame(ET_IPV4);
      add_random(19);
      send_frame();
   endtask

   initial begin
      int phase;
      board = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         // no idling, sender idle, receiver stalling, then both
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
            default: begin send_idle_pct = 26; recv_stall_pct = 26; end
         endcase
         case (phase)
            0: program_registers(HOME_ADDR, 1'b0, DNS_PORT);
            1: program_registers(32'h0, 1'b1, 16'h0);
            2: program_registers(BROADCAST, 1'b0, 16'hFFFF);
            3: program_registers($urandom(), 1'b1, DHCP_CLIENT);
            default: program_registers($urandom(), 1'($urandom_range(1)),
                                       ($urandom_range(3) == 0) ? DNS_PORT
                                                                : 16'($urandom()));
         endcase
         if (phase == 0) begin
            run_directed();
         end else begin
            bytes_sent  = 0;
            frames_sent = 0;
            while (bytes_sent < 60 || frames_sent < 2) begin
               make_random_frame();
               send_frame();
            end
         end
         settle();
      end
      if (board.errors == 0 && board.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
